// ===== sv/swipe_gesture_to_switch_keys_core_defines.svh =====
// ---------------------------------------------------------------------------
// Swipe switch-key core assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SWIPE_GESTURE_TO_SWITCH_KEYS_CORE_DEFINES_SVH
`define SWIPE_GESTURE_TO_SWITCH_KEYS_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset
`define SWGK_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swgk: same-cycle check failed");

// Next-cycle implication, held off during reset
`define SWGK_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swgk: next-cycle check failed");

`endif

// ===== sv/swgk_pkg.sv =====
// ---------------------------------------------------------------------------
// swgk_pkg
// Types, codes and key-run tables shared by the swipe switch-key core.
// ---------------------------------------------------------------------------
`default_nettype none

package swgk_pkg;

   localparam int SUM_BITS_DEF    = 32;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int THR_BITS        = 16;
   localparam int DELTA_BITS      = 16;

   localparam logic [15:0] ACT_THR_RESET = 16'd640;
   localparam logic [15:0] CYC_THR_RESET = 16'd1600;

   // event kinds
   localparam logic [1:0] CMD_BEGIN  = 2'd0;
   localparam logic [1:0] CMD_UPDATE = 2'd1;
   localparam logic [1:0] CMD_END    = 2'd2;
   localparam logic [1:0] CMD_CANCEL = 2'd3;

   localparam logic [2:0] SWIPE_FINGERS = 3'd3;

   // gesture modes
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_TRACK  = 2'd1;
   localparam logic [1:0] MODE_SWITCH = 2'd2;

   // keys
   localparam logic [1:0] KEY_ALT   = 2'd0;
   localparam logic [1:0] KEY_SHIFT = 2'd1;
   localparam logic [1:0] KEY_TAB   = 2'd2;
   localparam logic [1:0] KEY_ESC   = 2'd3;

   // configuration register indexes
   localparam logic CSR_ACT_THR = 1'b0;
   localparam logic CSR_CYC_THR = 1'b1;

   typedef logic [2:0] run_type;

   // key runs queued between front and back
   localparam run_type RUN_OPEN_FWD  = 3'd0;
   localparam run_type RUN_OPEN_BACK = 3'd1;
   localparam run_type RUN_STEP_FWD  = 3'd2;
   localparam run_type RUN_STEP_BACK = 3'd3;
   localparam run_type RUN_END       = 3'd4;
   localparam run_type RUN_CANCEL    = 3'd5;

   typedef struct packed {
      logic [1:0]               cmd;
      logic [2:0]               finger_count;
      logic signed [15:0]       delta_x;
      logic signed [15:0]       delta_y;
   } req_type;

   typedef struct packed {
      logic [1:0] key_id;
      logic       key_pressed;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] key_id;
      logic       key_pressed;
   } key_event_type;

   typedef struct packed {
      logic    valid;
      run_type run;
   } push_type;

   typedef struct packed {
      logic       busy;
      logic [1:0] mode;
      logic       alt;
   } front_status_type;

   function automatic logic [2:0] run_len(input run_type run);
      logic [2:0] len;
      case (run)
         RUN_OPEN_FWD:  len = 3'd3;
         RUN_OPEN_BACK: len = 3'd5;
         RUN_STEP_FWD:  len = 3'd2;
         RUN_STEP_BACK: len = 3'd4;
         RUN_END:       len = 3'd1;
         RUN_CANCEL:    len = 3'd3;
         default:       len = 3'd1;
      endcase
      return len;
   endfunction

   function automatic key_event_type key_ev(input logic [1:0] key, input logic pressed);
      key_event_type ev;
      ev.key_id      = key;
      ev.key_pressed = pressed;
      return ev;
   endfunction

   function automatic key_event_type run_key(input run_type run, input logic [2:0] idx);
      key_event_type ev;
      ev = key_ev(KEY_ALT, 1'b0);
      case (run)
         RUN_OPEN_FWD: begin
            case (idx)
               3'd0:    ev = key_ev(KEY_ALT, 1'b1);
               3'd1:    ev = key_ev(KEY_TAB, 1'b1);
               default: ev = key_ev(KEY_TAB, 1'b0);
            endcase
         end
         RUN_OPEN_BACK: begin
            case (idx)
               3'd0:    ev = key_ev(KEY_ALT, 1'b1);
               3'd1:    ev = key_ev(KEY_SHIFT, 1'b1);
               3'd2:    ev = key_ev(KEY_TAB, 1'b1);
               3'd3:    ev = key_ev(KEY_TAB, 1'b0);
               default: ev = key_ev(KEY_SHIFT, 1'b0);
            endcase
         end
         RUN_STEP_FWD: begin
            case (idx)
               3'd0:    ev = key_ev(KEY_TAB, 1'b1);
               default: ev = key_ev(KEY_TAB, 1'b0);
            endcase
         end
         RUN_STEP_BACK: begin
            case (idx)
               3'd0:    ev = key_ev(KEY_SHIFT, 1'b1);
               3'd1:    ev = key_ev(KEY_TAB, 1'b1);
               3'd2:    ev = key_ev(KEY_TAB, 1'b0);
               default: ev = key_ev(KEY_SHIFT, 1'b0);
            endcase
         end
         RUN_CANCEL: begin
            case (idx)
               3'd0:    ev = key_ev(KEY_ESC, 1'b1);
               3'd1:    ev = key_ev(KEY_ESC, 1'b0);
               default: ev = key_ev(KEY_ALT, 1'b0);
            endcase
         end
         default: ev = key_ev(KEY_ALT, 1'b0);
      endcase
      return ev;
   endfunction

endpackage

`default_nettype wire

// ===== sv/swgk_front.sv =====
// ---------------------------------------------------------------------------
// swgk_front
// Accepts gesture words, keeps mode and travel sums, decides key runs.
// ---------------------------------------------------------------------------
`default_nettype none

module swgk_front
   import swgk_pkg::*;
#(
   parameter int SUM_BITS = SUM_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire req_type          req_data,
   input  wire logic [15:0]      act_thr,
   input  wire logic [15:0]      cyc_thr,
   input  wire logic             q_full,
   output      push_type         push,
   output      front_status_type status
);

   localparam int W = SUM_BITS;
   localparam logic [W-1:0] SUM_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SUM_MIN = ~SUM_MAX;

   localparam logic [1:0] PH_FREE = 2'd0;
   localparam logic [1:0] PH_SUM  = 2'd1;
   localparam logic [1:0] PH_MEAS = 2'd2;
   localparam logic [1:0] PH_DEC  = 2'd3;

   logic [1:0]         phase_ff, phase_in;
   logic [1:0]         mode_ff, mode_in;
   logic               alt_ff, alt_in;
   logic signed [W-1:0] sum_x_ff, sum_x_in;
   logic signed [W-1:0] sum_y_ff, sum_y_in;
   logic signed [W-1:0] anchor_ff, anchor_in;
   logic signed [15:0] dx_ff, dx_in;
   logic signed [15:0] dy_ff, dy_in;
   logic [W-1:0]       ax_ff, ax_in;
   logic [W-1:0]       ay_ff, ay_in;
   logic signed [W:0]  t_ff, t_in;

   logic               accept;
   logic signed [W:0]  sx_wide, sy_wide;
   logic [W+2:0]       ax5, ay5, ax6, ay6;
   logic [W:0]         abs_t;
   logic               t_pos;

   assign req_stall = (phase_ff != PH_FREE) || q_full;
   assign accept    = req_valid && !req_stall;

   assign status.busy = (phase_ff != PH_FREE);
   assign status.mode = mode_ff;
   assign status.alt  = alt_ff;

   // saturating accumulate, one guard bit
   assign sx_wide = (W+1)'(sum_x_ff) + (W+1)'(dx_ff);
   assign sy_wide = (W+1)'(sum_y_ff) + (W+1)'(dy_ff);

   // five and six times the magnitudes
   assign ax5 = ({3'b000, ax_ff} << 2) + {3'b000, ax_ff};
   assign ay5 = ({3'b000, ay_ff} << 2) + {3'b000, ay_ff};
   assign ax6 = ({3'b000, ax_ff} << 2) + ({3'b000, ax_ff} << 1);
   assign ay6 = ({3'b000, ay_ff} << 2) + ({3'b000, ay_ff} << 1);

   assign abs_t = t_ff[W] ? (~t_ff + 1'b1) : t_ff;
   assign t_pos = !t_ff[W] && (t_ff != '0);

   always_comb begin
      phase_in   = phase_ff;
      mode_in    = mode_ff;
      alt_in     = alt_ff;
      sum_x_in   = sum_x_ff;
      sum_y_in   = sum_y_ff;
      anchor_in  = anchor_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      ax_in      = ax_ff;
      ay_in      = ay_ff;
      t_in       = t_ff;
      push.valid = 1'b0;
      push.run   = RUN_END;

      case (phase_ff)
         PH_FREE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_BEGIN: begin
                     if (req_data.finger_count == SWIPE_FINGERS && mode_ff == MODE_IDLE) begin
                        mode_in   = MODE_TRACK;
                        sum_x_in  = '0;
                        sum_y_in  = '0;
                        anchor_in = '0;
                     end
                  end
                  CMD_UPDATE: begin
                     if (mode_ff == MODE_TRACK || mode_ff == MODE_SWITCH) begin
                        dx_in    = req_data.delta_x;
                        dy_in    = req_data.delta_y;
                        phase_in = PH_SUM;
                     end
                  end
                  CMD_END: begin
                     if (mode_ff == MODE_SWITCH && alt_ff) begin
                        alt_in     = 1'b0;
                        push.valid = 1'b1;
                        push.run   = RUN_END;
                     end
                     mode_in = MODE_IDLE;
                  end
                  default: begin
                     if (mode_ff == MODE_SWITCH && alt_ff) begin
                        alt_in     = 1'b0;
                        push.valid = 1'b1;
                        push.run   = RUN_CANCEL;
                     end
                     mode_in = MODE_IDLE;
                  end
               endcase
            end
         end
         PH_SUM: begin
            if (sx_wide[W] != sx_wide[W-1]) begin
               sum_x_in = sx_wide[W] ? SUM_MIN : SUM_MAX;
            end else begin
               sum_x_in = sx_wide[W-1:0];
            end
            if (sy_wide[W] != sy_wide[W-1]) begin
               sum_y_in = sy_wide[W] ? SUM_MIN : SUM_MAX;
            end else begin
               sum_y_in = sy_wide[W-1:0];
            end
            phase_in = PH_MEAS;
         end
         PH_MEAS: begin
            ax_in    = sum_x_ff[W-1] ? (~sum_x_ff + 1'b1) : sum_x_ff;
            ay_in    = sum_y_ff[W-1] ? (~sum_y_ff + 1'b1) : sum_y_ff;
            t_in     = (W+1)'(sum_x_ff) - (W+1)'(anchor_ff);
            phase_in = PH_DEC;
         end
         default: begin
            phase_in = PH_FREE;
            if (mode_ff == MODE_TRACK) begin
               if (ax_ff > W'(act_thr) && ax5 > ay6) begin
                  alt_in     = 1'b1;
                  mode_in    = MODE_SWITCH;
                  anchor_in  = sum_x_ff;
                  push.valid = 1'b1;
                  push.run   = sum_x_ff[W-1] ? RUN_OPEN_FWD : RUN_OPEN_BACK;
               end else if (ay_ff > W'(act_thr) && ay5 > ax6) begin
                  mode_in = MODE_IDLE;
               end
            end else begin
               if (abs_t >= (W+1)'(cyc_thr)) begin
                  anchor_in  = sum_x_ff;
                  push.valid = 1'b1;
                  push.run   = t_pos ? RUN_STEP_FWD : RUN_STEP_BACK;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FREE;
         mode_ff   <= MODE_IDLE;
         alt_ff    <= 1'b0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         anchor_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         mode_ff   <= mode_in;
         alt_ff    <= alt_in;
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         anchor_ff <= anchor_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      t_ff  <= t_in;
   end

endmodule

`default_nettype wire

// ===== sv/swgk_queue.sv =====
// ---------------------------------------------------------------------------
// swgk_queue
// Short run-code queue between the front and the key sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module swgk_queue
   import swgk_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   input  wire logic     pop,
   output      logic     full,
   output      logic     head_valid,
   output      run_type  head_run
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   run_type          q_mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_run   = q_mem[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem[wr_ptr_ff] <= push.run;
      end
   end

endmodule

`default_nettype wire

// ===== sv/swgk_back.sv =====
// ---------------------------------------------------------------------------
// swgk_back
// Expands queued run codes into key words, one per cycle unless rsp_stall holds, registered out.
// ---------------------------------------------------------------------------
`default_nettype none

module swgk_back
   import swgk_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    head_valid,
   input  wire run_type head_run,
   output      logic    pop,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   logic          out_valid_ff, out_valid_in;
   rsp_type       out_data_ff, out_data_in;
   logic [2:0]    idx_ff, idx_in;
   logic          load, last;
   key_event_type ev;

   assign load = !out_valid_ff || !rsp_stall;
   assign ev   = run_key(head_run, idx_ff);
   assign last = (idx_ff == run_len(head_run) - 3'd1);
   assign pop  = load && head_valid && last;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      idx_in       = idx_ff;
      if (load) begin
         out_valid_in = head_valid;
         if (head_valid) begin
            out_data_in.key_id      = ev.key_id;
            out_data_in.key_pressed = ev.key_pressed;
            out_data_in.last_of_run = last;
            idx_in                  = last ? 3'd0 : idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // hold payload while stalled
   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== sv/swipe_gesture_to_switch_keys_core.sv =====
// ---------------------------------------------------------------------------
// swipe_gesture_to_switch_keys_core
// Turns swipe gesture words into key press/release runs for a window switcher.
// ---------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req_     in   req_valid / req_stall  req_type (cmd, fingers, deltas)
//  rsp_     out  rsp_valid / rsp_stall  rsp_type (key, pressed, last)
//  csr_     in   csr_we                 csr_index, csr_wdata
//
//  Begin, end and cancel words, and updates outside a gesture, are taken without
//  busying the front; an update during a gesture occupies the front through its
//  steps (take, accumulate, magnitudes, decide).
//  The back sends one key word per cycle while rsp_stall is low, one to five
//  per run, fed by a four-entry run queue.
//  Reset is synchronous: idle mode, zero sums, thresholds 640 and 1600, empty queue.
//  rsp_stall holds the output register; req_stall rises while an update is
//  worked through and when the queue fills.
// ---------------------------------------------------------------------------
`default_nettype none
`include "swipe_gesture_to_switch_keys_core_defines.svh"

module swipe_gesture_to_switch_keys_core
   import swgk_pkg::*;
#(
   parameter int SUM_BITS    = SUM_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      rsp_type     rsp_data,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic [15:0]      act_thr_ff, act_thr_in;
   logic [15:0]      cyc_thr_ff, cyc_thr_in;
   push_type         push;
   front_status_type front_status;
   logic             q_full, head_valid, pop;
   run_type          head_run;

   always_comb begin
      act_thr_in = act_thr_ff;
      cyc_thr_in = cyc_thr_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ACT_THR: act_thr_in = csr_wdata;
            CSR_CYC_THR: cyc_thr_in = csr_wdata;
            default:     act_thr_in = act_thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_thr_ff <= ACT_THR_RESET;
         cyc_thr_ff <= CYC_THR_RESET;
      end else begin
         act_thr_ff <= act_thr_in;
         cyc_thr_ff <= cyc_thr_in;
      end
   end

   swgk_front #(
      .SUM_BITS (SUM_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .act_thr   (act_thr_ff),
      .cyc_thr   (cyc_thr_ff),
      .q_full    (q_full),
      .push      (push),
      .status    (front_status)
   );

   swgk_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_run   (head_run)
   );

   swgk_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_run   (head_run),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // Alt is held for as long as the switcher is open
   `SWGK_ASSERT_IMP(a_alt_in_switch, clock, reset, front_status.mode == MODE_SWITCH, front_status.alt)
   // a run is never pushed into a full queue
   `SWGK_ASSERT_IMP(a_no_push_full, clock, reset, push.valid, !q_full)
   // hold off new words while an update is worked through
   `SWGK_ASSERT_IMP(a_stall_when_busy, clock, reset, front_status.busy, req_stall)
   // a run goes out without gaps until its last key
   `SWGK_ASSERT_NXT(a_run_unbroken, clock, reset, rsp_valid && !rsp_stall && !rsp_data.last_of_run, rsp_valid)

endmodule

`default_nettype wire
